FILE: rtl/yrp_pkg.sv
`timescale 1ns / 1ps
// Package for the yaw-rate PID: register indexes, reset values, widths.
// No dependencies.
package yrp_pkg;

    localparam int CFG_W   = 32;
    localparam int ADDR_W  = 3;
    localparam int DIV_W   = 82;
    localparam int DVSR_W  = 32;
    localparam int MUL_W   = 34;

    localparam logic [ADDR_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [ADDR_W-1:0] REG_KP     = 3'd1;
    localparam logic [ADDR_W-1:0] REG_KI     = 3'd2;
    localparam logic [ADDR_W-1:0] REG_KD     = 3'd3;
    localparam logic [ADDR_W-1:0] REG_ALPHA  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_LIMIT  = 3'd5;
    localparam logic [ADDR_W-1:0] REG_INVERT = 3'd6;

    localparam logic signed [31:0] KP_RST    = 32'sd1311;
    localparam logic signed [31:0] KD_RST    = 32'sd6554;
    localparam logic [15:0]        ALPHA_RST = 16'd66;
    localparam logic [9:0]         LIMIT_RST = 10'd100;

    // integral scale 2^8 * 10^6 = 2^14 * 15625; floor(2^40 / 15625)
    localparam logic [MUL_W-1:0]   I_DIV_C  = 34'd15625;
    localparam logic [MUL_W-1:0]   I_RECIP  = 34'd70368744;
    localparam logic [MUL_W-1:0]   US_SCALE = 34'd1000000;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

endpackage

FILE: rtl/yaw_rate_pid_with_input_filter.sv
`timescale 1ns / 1ps
// Yaw-rate PID with input low-pass filter: config registers and sequencer.
// Uses yrp_pkg, yrp_mul, yrp_div.
//
//  channel | signals                         | contents
//  s_      | s_tvalid s_tready s_tdata[31:0] | yaw_rate, step_time_us
//  m_      | m_tvalid m_tready m_tdata[15:0] | yaw_drive
//  cfg     | cfg_we cfg_addr cfg_wdata       | register writes
//
// When enabled, a request runs the filter, error, P, I and D multiplier steps and a
// serial divide for the derivative, skipping the integral quotient steps when the
// integral term saturates; when disabled it clears filter state and goes to done.
// Synchronous active-low reset loads register defaults and clears filter state.
// A new request is taken while a result waits on m_; finishing stalls on m_tready.
module yaw_rate_pid_with_input_filter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // yaw_rate, step_time_us
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // yaw_drive, zero pad
    input  logic                          cfg_we,
    input  logic [yrp_pkg::ADDR_W-1:0]    cfg_addr,
    input  logic [yrp_pkg::CFG_W-1:0]     cfg_wdata
);
    import yrp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_F_MUL, S_F_UPD, S_E_MUL, S_E_UPD, S_P_MUL, S_P_UPD,
        S_IH_MUL, S_IH_UPD, S_IL_MUL, S_IL_UPD, S_IQ_MUL, S_IQ_UPD,
        S_IR_MUL, S_IR_UPD,
        S_D_MUL, S_D_UPD, S_DL_MUL, S_DL_UPD, S_DH_MUL, S_DH_UPD, S_D_DIV,
        S_SUM, S_RND, S_DONE
    } state_t;

    state_t state_reg;

    logic               en_reg, inv_reg;
    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic [15:0]        alpha_reg;
    logic [9:0]         lim_reg;

    logic signed [31:0] filt_reg, err_reg, perr_reg;
    logic signed [47:0] integ_reg;
    logic signed [15:0] rate_reg;
    logic [15:0]        dt_reg;
    logic signed [32:0] de_reg;
    logic [47:0]        imag_reg;
    logic               ineg_reg, dneg_reg;
    logic signed [47:0] p_reg;
    logic [55:0]        hi_reg;
    logic [39:0]        xq_reg;
    logic [26:0]        q0_reg;
    logic signed [26:0] i_reg;
    logic [61:0]        dprod_reg;
    logic [51:0]        nlo_reg;
    logic signed [51:0] d_reg;
    logic signed [27:0] u_reg;
    logic [10:0]        res_reg;
    logic               m_tvalid_reg;
    logic [10:0]        m_data_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    div_req_t                  div_req;
    logic                      div_done;
    logic [DIV_W-1:0]          div_q;

    logic [31:0]        ki_mag, kd_mag;
    logic [32:0]        de_mag;
    logic signed [31:0] filt_next;
    logic signed [48:0] isum;
    logic signed [47:0] isat;
    logic [25:0]        lim_q;
    logic signed [53:0] usum;
    logic signed [27:0] uclamp;
    logic signed [11:0] ip;
    logic               rnd_up;
    logic [63:0]        iprod;
    logic [40:0]        ir_rem;
    logic [27:0]        iq;

    yrp_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p(mul_p));
    yrp_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req),
                   .done(div_done), .quotient(div_q));

    assign ki_mag = ki_reg[31] ? 32'(-ki_reg) : 32'(ki_reg);
    assign kd_mag = kd_reg[31] ? 32'(-kd_reg) : 32'(kd_reg);
    assign de_mag = de_reg[32] ? 33'(-de_reg) : 33'(de_reg);
    assign lim_q  = {lim_reg, 16'b0};

    assign filt_next = filt_reg + mul_p[47:16];
    assign isum = {integ_reg[47], integ_reg} + {mul_p[55], mul_p[55:8]};
    assign isat = (isum[48] != isum[47]) ? {isum[48], {47{~isum[48]}}} : isum[47:0];
    assign iprod = {1'b0, hi_reg[38:0], 24'b0} + mul_p[63:0];

    // reciprocal estimate is low by at most two divisors
    assign ir_rem = {1'b0, xq_reg} - mul_p[40:0];
    assign iq     = 28'(q0_reg) + 28'(ir_rem >= 41'(I_DIV_C))
                  + 28'(ir_rem >= 41'(I_DIV_C) + 41'(I_DIV_C));

    assign usum = 54'(p_reg) + 54'(i_reg) + 54'(d_reg);
    assign uclamp = (usum > 54'(signed'({1'b0, lim_q}))) ? 28'(signed'({1'b0, lim_q}))
                  : (usum < -54'(signed'({1'b0, lim_q}))) ? -28'(signed'({1'b0, lim_q}))
                  : usum[27:0];

    assign ip     = u_reg[27:16];
    assign rnd_up = (u_reg[15:0] > 16'h8000) || (u_reg[15:0] == 16'h8000 && ip[0]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_F_MUL: begin
                mul_a = MUL_W'({1'b0, alpha_reg});
                mul_b = 34'(signed'({rate_reg, 12'b0})) - 34'(filt_reg);
            end
            S_E_MUL: begin
                mul_a = 34'(err_reg);
                mul_b = MUL_W'({1'b0, dt_reg});
            end
            S_P_MUL: begin
                mul_a = 34'(kp_reg);
                mul_b = 34'(err_reg);
            end
            S_IH_MUL: begin
                mul_a = MUL_W'({1'b0, ki_mag});
                mul_b = MUL_W'({1'b0, imag_reg[47:24]});
            end
            S_IL_MUL: begin
                mul_a = MUL_W'({1'b0, ki_mag});
                mul_b = MUL_W'({1'b0, imag_reg[23:0]});
            end
            S_IQ_MUL: begin
                mul_a = MUL_W'({1'b0, xq_reg[39:10]});
                mul_b = I_RECIP;
            end
            S_IR_MUL: begin
                mul_a = MUL_W'({1'b0, q0_reg});
                mul_b = I_DIV_C;
            end
            S_D_MUL: begin
                mul_a = MUL_W'({1'b0, kd_mag});
                mul_b = signed'({1'b0, de_mag});
            end
            S_DL_MUL: begin
                mul_a = MUL_W'({1'b0, dprod_reg[31:0]});
                mul_b = US_SCALE;
            end
            S_DH_MUL: begin
                mul_a = MUL_W'({1'b0, dprod_reg[61:32]});
                mul_b = US_SCALE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_req = '0;
        case (state_reg)
            S_DH_UPD: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({mul_p[49:0], 32'b0}) + DIV_W'(nlo_reg);
                div_req.divisor  = {dt_reg, 16'b0};
            end
            default: div_req = '0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            en_reg       <= 1'b1;
            kp_reg       <= KP_RST;
            ki_reg       <= '0;
            kd_reg       <= KD_RST;
            alpha_reg    <= ALPHA_RST;
            lim_reg      <= LIMIT_RST;
            inv_reg      <= 1'b1;
            filt_reg     <= '0;
            integ_reg    <= '0;
            perr_reg     <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
                m_tvalid_reg <= 1'b0;

            if (cfg_we) begin
                case (cfg_addr)
                    REG_ENABLE: en_reg    <= cfg_wdata[0];
                    REG_KP:     kp_reg    <= cfg_wdata;
                    REG_KI: begin
                        ki_reg <= cfg_wdata;
                        if (cfg_wdata == '0)
                            integ_reg <= '0;
                    end
                    REG_KD:     kd_reg    <= cfg_wdata;
                    REG_ALPHA:  alpha_reg <= cfg_wdata[15:0];
                    REG_LIMIT:  lim_reg   <= cfg_wdata[9:0];
                    REG_INVERT: inv_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        rate_reg <= s_tdata[15:0];
                        dt_reg   <= (s_tdata[31:16] == '0) ? 16'd1 : s_tdata[31:16];
                        if (en_reg) begin
                            state_reg <= S_F_MUL;
                        end else begin
                            filt_reg  <= '0;
                            integ_reg <= '0;
                            perr_reg  <= '0;
                            res_reg   <= '0;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_F_MUL: state_reg <= S_F_UPD;
                S_F_UPD: begin
                    filt_reg  <= filt_next;
                    err_reg   <= -filt_next;
                    state_reg <= S_E_MUL;
                end
                S_E_MUL: state_reg <= S_E_UPD;
                S_E_UPD: begin
                    integ_reg <= isat;
                    state_reg <= S_P_MUL;
                end
                S_P_MUL: begin
                    de_reg    <= 33'(err_reg) - 33'(perr_reg);
                    perr_reg  <= err_reg;
                    imag_reg  <= integ_reg[47] ? 48'(-integ_reg) : 48'(integ_reg);
                    ineg_reg  <= ki_reg[31] ^ integ_reg[47];
                    state_reg <= S_P_UPD;
                end
                S_P_UPD: begin
                    p_reg     <= mul_p[63:16];
                    dneg_reg  <= kd_reg[31] ^ de_reg[32];
                    state_reg <= S_IH_MUL;
                end
                S_IH_MUL: state_reg <= S_IH_UPD;
                S_IH_UPD: begin
                    hi_reg    <= mul_p[55:0];
                    state_reg <= S_IL_MUL;
                end
                S_IL_MUL: state_reg <= S_IL_UPD;
                S_IL_UPD: begin
                    xq_reg <= iprod[53:14];
                    if (hi_reg[55:39] != '0 || iprod[63:54] != '0) begin
                        i_reg     <= ineg_reg ? -27'(signed'({1'b0, lim_q}))
                                              : 27'(signed'({1'b0, lim_q}));
                        state_reg <= S_D_MUL;
                    end else begin
                        state_reg <= S_IQ_MUL;
                    end
                end
                S_IQ_MUL: state_reg <= S_IQ_UPD;
                S_IQ_UPD: begin
                    q0_reg    <= mul_p[56:30];
                    state_reg <= S_IR_MUL;
                end
                S_IR_MUL: state_reg <= S_IR_UPD;
                S_IR_UPD: begin
                    if (iq > 28'(lim_q))
                        i_reg <= ineg_reg ? -27'(signed'({1'b0, lim_q}))
                                          : 27'(signed'({1'b0, lim_q}));
                    else
                        i_reg <= ineg_reg ? -27'(signed'({1'b0, iq[25:0]}))
                                          : 27'(signed'({1'b0, iq[25:0]}));
                    state_reg <= S_D_MUL;
                end
                S_D_MUL: state_reg <= S_D_UPD;
                S_D_UPD: begin
                    dprod_reg <= mul_p[61:0];
                    state_reg <= S_DL_MUL;
                end
                S_DL_MUL: state_reg <= S_DL_UPD;
                S_DL_UPD: begin
                    nlo_reg   <= mul_p[51:0];
                    state_reg <= S_DH_MUL;
                end
                S_DH_MUL: state_reg <= S_DH_UPD;
                S_DH_UPD: state_reg <= S_D_DIV;
                S_D_DIV: begin
                    if (div_done) begin
                        if (div_q[DIV_W-1:50] != '0)
                            d_reg <= dneg_reg ? -52'sh4000000000000 : 52'sh4000000000000;
                        else
                            d_reg <= dneg_reg ? -52'(signed'({1'b0, div_q[50:0]}))
                                              : 52'(signed'({1'b0, div_q[50:0]}));
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    u_reg     <= inv_reg ? -uclamp : uclamp;
                    state_reg <= S_RND;
                end
                S_RND: begin
                    res_reg   <= 11'(ip + 12'(rnd_up));
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= res_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/yrp_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Uses yrp_pkg.
module yrp_mul (
    input  logic                                aclk,
    input  logic signed [yrp_pkg::MUL_W-1:0]    a,
    input  logic signed [yrp_pkg::MUL_W-1:0]    b,
    output logic signed [2*yrp_pkg::MUL_W-1:0]  p
);
    import yrp_pkg::*;

    logic signed [2*MUL_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule

FILE: rtl/yrp_div.sv
`timescale 1ns / 1ps
// Serial restoring divider, one quotient bit per cycle.
// Uses yrp_pkg.
module yrp_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  yrp_pkg::div_req_t            req,
    output logic                         done,
    output logic [yrp_pkg::DIV_W-1:0]    quotient
);
    import yrp_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVSR_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvsr_reg <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? DVSR_W'(trial - {1'b0, dvsr_reg}) : trial[DVSR_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
